/* rtl/core/mcp_pkg.sv */
// ----------------------------------------------------------------------------
// mcp_pkg: shared types and constants of the mean-centered projection block
// Sizes, operation codes, register indexes and the transaction types that
// travel between the front, back and result queue.
// ----------------------------------------------------------------------------
package mcp_pkg;

   localparam int MAX_DIM      = 1024;
   localparam int MAX_COMPS    = 16;
   localparam int DIM_W        = $clog2(MAX_DIM);
   localparam int COMP_W       = $clog2(MAX_COMPS);
   localparam int DIM_CFG_W    = 11;
   localparam int COMP_CFG_W   = 5;
   localparam int VALUE_W      = 16;
   localparam int ACC_W        = 48;
   localparam int ROW_W        = 16;
   localparam int OP_W         = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int CMD_DEPTH    = 4;
   localparam int CMD_PTR_W    = $clog2(CMD_DEPTH);
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_W    = $clog2(RSP_DEPTH);

   localparam logic [OP_W-1:0] OP_LOAD_WEIGHT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_MEAN   = 2'd1;
   localparam logic [OP_W-1:0] OP_SAMPLE      = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_USE_MEAN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPS    = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic [DIM_W-1:0]          position;
      logic [COMP_W-1:0]         component;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic                  use_mean;
      logic [DIM_CFG_W-1:0]  dim;
      logic [COMP_CFG_W-1:0] comps;
   } cfg_type;

   typedef struct packed {
      logic [COMP_W-1:0]       component;
      logic signed [ACC_W-1:0] projection;
      logic [ROW_W-1:0]        row_number;
      logic                    last;
   } rsp_type;

endpackage

/* rtl/core/mcp_front.sv */
// ----------------------------------------------------------------------------
// mcp_front: input acceptance and command queue
// Takes input transactions, drops the unused operation code and holds the
// rest in a short queue until the back end pops them.
// ----------------------------------------------------------------------------
module mcp_front import mcp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [OP_W-1:0]           req_operation,
   input  logic [DIM_W-1:0]          req_position,
   input  logic [COMP_W-1:0]         req_component,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      cmd_pop,
   output logic                      cmd_valid,
   output cmd_type                   cmd
);

   cmd_type                queue_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_W:0]     count_ff, count_in;
   logic                   accept;
   logic                   keep;
   logic                   take;

   assign req_full  = (count_ff == (CMD_PTR_W+1)'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   assign accept = req_push && !req_full;
   // drop the unused operation code here, it has no effect downstream
   assign keep   = accept && (req_operation != OP_UNUSED);
   assign take   = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = keep ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (keep && !take) begin
         count_in = count_ff + 1'b1;
      end else if (!keep && take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         queue_ff[wr_ptr_ff] <= '{op: req_operation, position: req_position,
                                  component: req_component, value: req_value};
      end
   end

endmodule

/* rtl/core/mcp_back.sv */
// ----------------------------------------------------------------------------
// mcp_back: store updates and multiply-accumulate sequencer
// Pops commands, writes the weight and mean stores, runs one shared
// multiplier over the active components per sample and emits row results.
// ----------------------------------------------------------------------------
module mcp_back import mcp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_push,
   input  logic    rsp_full,
   output rsp_type rsp
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_DIFF  = 3'd2;
   localparam logic [2:0] S_MAC   = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic signed [VALUE_W-1:0] weight_mem [MAX_DIM*MAX_COMPS];
   logic signed [VALUE_W-1:0] mean_mem   [MAX_DIM];

   logic [2:0]                state_ff, state_in;
   cmd_type                   cur_ff, cur_in;
   logic [DIM_W-1:0]          elem_ff, elem_in;
   logic [COMP_W-1:0]         comp_ff, comp_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic signed [VALUE_W:0]   diff_ff, diff_in;
   logic signed [VALUE_W-1:0] mean_rd_ff;
   logic signed [VALUE_W-1:0] w_rd_ff;
   logic                      valid_b_ff;
   logic [COMP_W-1:0]         comp_b_ff;
   logic                      valid_c_ff;
   logic [COMP_W-1:0]         comp_c_ff;
   logic signed [2*VALUE_W:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff [MAX_COMPS];

   logic                      weight_we;
   logic                      mean_we;
   logic                      clear_acc;
   logic [DIM_CFG_W-1:0]      dim_eff;
   logic [COMP_CFG_W-1:0]     comps_eff;
   logic                      last_comp;
   logic                      row_done;

   // clamp the sizes into their legal ranges
   always_comb begin
      dim_eff = cfg.dim;
      if (cfg.dim == '0) begin
         dim_eff = DIM_CFG_W'(1);
      end else if (cfg.dim > DIM_CFG_W'(MAX_DIM)) begin
         dim_eff = DIM_CFG_W'(MAX_DIM);
      end
      comps_eff = cfg.comps;
      if (cfg.comps == '0) begin
         comps_eff = COMP_CFG_W'(1);
      end else if (cfg.comps > COMP_CFG_W'(MAX_COMPS)) begin
         comps_eff = COMP_CFG_W'(MAX_COMPS);
      end
   end

   assign last_comp = (COMP_CFG_W'(comp_ff) == comps_eff - COMP_CFG_W'(1));
   assign row_done  = !(DIM_CFG_W'(elem_ff) + DIM_CFG_W'(1) < dim_eff);
   assign prod_in   = diff_ff * w_rd_ff;

   assign rsp.component  = comp_ff;
   assign rsp.projection = acc_ff[comp_ff];
   assign rsp.row_number = row_ff;
   assign rsp.last       = last_comp;

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      elem_in   = elem_ff;
      comp_in   = comp_ff;
      row_in    = row_ff;
      diff_in   = diff_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      weight_we = 1'b0;
      mean_we   = 1'b0;
      clear_acc = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            case (cur_ff.op)
               OP_LOAD_WEIGHT: weight_we = 1'b1;
               OP_LOAD_MEAN:   mean_we   = 1'b1;
               OP_SAMPLE:      state_in  = S_DIFF;
               default:        state_in  = S_IDLE;
            endcase
         end
         S_DIFF: begin
            diff_in = {cur_ff.value[VALUE_W-1], cur_ff.value};
            if (cfg.use_mean) begin
               diff_in = {cur_ff.value[VALUE_W-1], cur_ff.value}
                       - {mean_rd_ff[VALUE_W-1], mean_rd_ff};
            end
            comp_in  = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            if (last_comp) begin
               state_in = S_DRAIN;
            end else begin
               comp_in = comp_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (!valid_b_ff && !valid_c_ff) begin
               if (row_done) begin
                  comp_in  = '0;
                  state_in = S_EMIT;
               end else begin
                  elem_in  = elem_ff + 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (last_comp) begin
                  clear_acc = 1'b1;
                  elem_in   = '0;
                  row_in    = row_ff + 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  comp_in = comp_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         elem_ff    <= '0;
         comp_ff    <= '0;
         row_ff     <= '0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         elem_ff    <= elem_in;
         comp_ff    <= comp_in;
         row_ff     <= row_in;
         valid_b_ff <= (state_ff == S_MAC);
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      diff_ff   <= diff_in;
      comp_b_ff <= comp_ff;
      comp_c_ff <= comp_b_ff;
      prod_ff   <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (weight_we) begin
         weight_mem[{cur_ff.position, cur_ff.component}] <= cur_ff.value;
      end
      w_rd_ff <= weight_mem[{elem_ff, comp_ff}];
   end

   always_ff @(posedge clock) begin
      if (mean_we) begin
         mean_mem[cur_ff.position] <= cur_ff.value;
      end
      mean_rd_ff <= mean_mem[elem_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || clear_acc) begin
         for (int i = 0; i < MAX_COMPS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (valid_c_ff) begin
         acc_ff[comp_c_ff] <= acc_ff[comp_c_ff] + ACC_W'(prod_ff);
      end
   end

   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff |=> valid_c_ff)
      else $error("multiplier stage lost a product");

   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (!valid_b_ff && !valid_c_ff))
      else $error("results emitted while products still in flight");

   a_acc_window: assert property (@(posedge clock) disable iff (reset)
      valid_c_ff |-> (state_ff == S_MAC || state_ff == S_DRAIN))
      else $error("accumulate outside a sample pass");

   a_pop_exec: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff == S_EXEC))
      else $error("popped command not executed");

endmodule

/* rtl/core/mcp_rsp_queue.sv */
// ----------------------------------------------------------------------------
// mcp_rsp_queue: result queue
// Holds finished results so the back end keeps working while the consumer
// stalls.
// ----------------------------------------------------------------------------
module mcp_rsp_queue import mcp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  rsp_type push_data,
   input  logic    pop,
   output logic    empty,
   output rsp_type head
);

   rsp_type              queue_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_PTR_W:0]   count_ff, count_in;
   logic                 put;
   logic                 take;

   assign full  = (count_ff == (RSP_PTR_W+1)'(RSP_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = queue_ff[rd_ptr_ff];
   assign put   = push && !full;
   assign take  = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (put && !take) begin
         count_in = count_ff + 1'b1;
      end else if (!put && take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (put) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/mean_centered_projection.sv */
// ----------------------------------------------------------------------------
// mean_centered_projection: fixed-point projection of sample rows on a basis
// Flow: a load transaction is written to its store by the back end; a sample
//   element passes through the back end (one shared 17x16 multiplier
//   walks the active components), and the row-closing element then hands
//   out the results, one per cycle while the result queue is not full.
// The back end takes the next element only after finishing the current one.
// Reset: synchronous; clears queues, counters and accumulators and restores
//   use_mean=1, dim_in_use=1024, comps_in_use=16. Stores stay undefined.
// ----------------------------------------------------------------------------
module mean_centered_projection import mcp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // input transactions
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [OP_W-1:0]           req_operation,
   input  logic [DIM_W-1:0]          req_position,
   input  logic [COMP_W-1:0]         req_component,
   input  logic signed [VALUE_W-1:0] req_value,
   // result transactions
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [COMP_W-1:0]         rsp_out_component,
   output logic signed [ACC_W-1:0]   rsp_projection,
   output logic [ROW_W-1:0]          rsp_row_number,
   output logic                      rsp_last,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    rsp_push;
   logic    rsp_full;
   rsp_type rsp_data;
   rsp_type rsp_head;

   // Register writes take effect on the next clock edge, so the port never stalls.
   assign csr_ready = 1'b1;

   // Decode the register index; writes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_USE_MEAN: cfg_in.use_mean = csr_data[0];
            CSR_DIM:      cfg_in.dim      = csr_data[DIM_CFG_W-1:0];
            CSR_COMPS:    cfg_in.comps    = csr_data[COMP_CFG_W-1:0];
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.use_mean <= 1'b1;
         cfg_ff.dim      <= DIM_CFG_W'(MAX_DIM);
         cfg_ff.comps    <= COMP_CFG_W'(MAX_COMPS);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept transactions and hold them for the back end.
   mcp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_position  (req_position),
      .req_component (req_component),
      .req_value     (req_value),
      .cmd_pop       (cmd_pop),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd)
   );

   // Back: update stores, accumulate per component, emit row results.
   mcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full),
      .rsp       (rsp_data)
   );

   // Result queue: decouple the back end from a stalling consumer.
   mcp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .full      (rsp_full),
      .push_data (rsp_data),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   assign rsp_out_component = rsp_head.component;
   assign rsp_projection    = rsp_head.projection;
   assign rsp_row_number    = rsp_head.row_number;
   assign rsp_last          = rsp_head.last;

endmodule
